[rtl/fcw_pkg.sv]
package fcw_pkg;

    localparam int FLOW_FRAC_BITS = 16;
    localparam int WHITE_LIMIT    = 10000;
    localparam int WHEEL_SIZE     = 55;
    localparam int CORDIC_STEPS   = 15;
    localparam int SQRT_STEPS     = FLOW_FRAC_BITS + 1;
    localparam int N_CELLS        = (SQRT_STEPS > CORDIC_STEPS) ? SQRT_STEPS : CORDIC_STEPS;
    localparam int IDX_W          = $clog2(N_CELLS);
    localparam int XY_W           = 36;
    localparam int Z_W            = 16;
    localparam int SQ_W           = 2 * FLOW_FRAC_BITS + 2;
    localparam int R_W            = FLOW_FRAC_BITS + 1;
    localparam int C_W            = 24;
    localparam int P_W            = R_W + C_W;
    localparam int OUT_SHIFT      = 16 + FLOW_FRAC_BITS;

    localparam logic signed [63:0] WHITE_RAW = 64'(WHITE_LIMIT) << FLOW_FRAC_BITS;
    localparam logic [63:0] UNIT_SQ = 64'(1) << (2 * FLOW_FRAC_BITS);
    localparam logic [Z_W-1:0] HALF_TURN = 16'h8000;
    localparam logic [C_W-1:0] FULL_C = 24'(255 * 65536);

    typedef logic [N_CELLS-1:0][Z_W-1:0] t_turn;
    typedef logic [WHEEL_SIZE-1:0][23:0] t_wheel;

    function automatic t_turn build_turn();
        int tab [15];
        t_turn t;
        tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        t = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t[i] = Z_W'(tab[i]);
        end
        return t;
    endfunction

    function automatic t_wheel build_wheel();
        t_wheel w;
        int r;
        int g;
        int b;
        int j;
        for (int k = 0; k < WHEEL_SIZE; k++) begin
            if (k < 15) begin
                r = 255; g = 255 * k / 15; b = 0;
            end else if (k < 21) begin
                j = k - 15; r = 255 - 255 * j / 6; g = 255; b = 0;
            end else if (k < 25) begin
                j = k - 21; r = 0; g = 255; b = 255 * j / 4;
            end else if (k < 36) begin
                j = k - 25; r = 0; g = 255 - 255 * j / 11; b = 255;
            end else if (k < 49) begin
                j = k - 36; r = 255 * j / 13; g = 0; b = 255;
            end else begin
                j = k - 49; r = 255; g = 0; b = 255 - 255 * j / 6;
            end
            w[k] = {8'(r), 8'(g), 8'(b)};
        end
        return w;
    endfunction

    localparam t_turn  TURN  = build_turn();
    localparam t_wheel WHEEL = build_wheel();

    typedef struct packed {
        logic                   valid;
        logic                   white;
        logic                   fe;
        logic                   in_unit;
        logic                   zy;
        logic [Z_W-1:0]         zt;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
        logic [SQ_W-1:0]        n;
        logic [SQ_W-1:0]        res;
    } t_cell;

endpackage

[rtl/fcw_cell.sv]
module fcw_cell
    import fcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell            i_d,
    output t_cell            o_q
);

    t_cell r_q;
    t_cell n_q;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;

    // one CORDIC rotation (in the first CORDIC_STEPS cells) and one root digit per cell
    always_comb begin
        n_q   = i_d;
        dx    = i_d.y >>> i_idx;
        dy    = i_d.x >>> i_idx;
        bit_v = '0;
        trial = '0;
        if (int'(i_idx) < CORDIC_STEPS) begin
            if (i_d.y > 0) begin
                n_q.x = i_d.x + dx;
                n_q.y = i_d.y - dy;
                n_q.z = i_d.z + TURN[i_idx];
            end else begin
                n_q.x = i_d.x - dx;
                n_q.y = i_d.y + dy;
                n_q.z = i_d.z - TURN[i_idx];
            end
        end
        if (int'(i_idx) < SQRT_STEPS) begin
            bit_v = SQ_W'(1) << (2 * FLOW_FRAC_BITS - 2 * int'(i_idx));
            trial = i_d.res + bit_v;
            if (i_d.n >= trial) begin
                n_q.n   = i_d.n - trial;
                n_q.res = (i_d.res >> 1) + bit_v;
            end else begin
                n_q.res = i_d.res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/fcw_color.sv]
module fcw_color
    import fcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell      i_d,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_frame_done
);

    typedef struct packed {
        logic valid;
        logic white;
        logic fe;
        logic in_unit;
    } t_tag;

    t_tag r_t1, r_t2, r_t3, r_t4;
    logic [R_W-1:0] r_r1, r_r2;
    logic [5:0]     r_k0;
    logic [15:0]    r_f;
    logic [2:0][C_W-1:0] r_c;
    logic [2:0][P_W-1:0] r_p;
    logic [2:0][7:0]     r_hi;
    logic [2:0][7:0]     r_o;

    logic [Z_W-1:0] t;
    logic [21:0]    fk;
    logic [23:0]    w0, w1;
    logic [16:0]    fi;
    logic [2:0][C_W-1:0] n_c;
    logic [2:0][P_W-1:0] n_p;
    logic [2:0][7:0]     n_o;
    logic [P_W-1:0] q;

    always_comb begin
        t  = i_d.zy ? i_d.zt : i_d.z;
        fk = 22'(t) * 22'(54);
        w0 = WHEEL[r_k0];
        w1 = WHEEL[r_k0 + 6'd1];
        fi = 17'h10000 - 17'(r_f);
        for (int ch = 0; ch < 3; ch++) begin
            n_c[ch] = C_W'(25'(fi) * 25'(w0[8*(2-ch) +: 8])
                         + 25'(r_f) * 25'(w1[8*(2-ch) +: 8]));
            n_p[ch] = P_W'(r_r2) * P_W'(FULL_C - r_c[ch]);
        end
        q = '0;
        for (int ch = 0; ch < 3; ch++) begin
            q = (r_p[ch] + ((P_W'(1) << OUT_SHIFT) - P_W'(1))) >> OUT_SHIFT;
            if (r_t3.white) begin
                n_o[ch] = 8'hFF;
            end else if (!r_t3.in_unit) begin
                n_o[ch] = r_hi[ch];
            end else if (q >= P_W'(255)) begin
                n_o[ch] = 8'h00;
            end else begin
                n_o[ch] = 8'(P_W'(255) - q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
            r_t4.valid <= 1'b0;
        end else if (i_en) begin
            // wheel position
            r_t1 <= '{valid: i_d.valid, white: i_d.white, fe: i_d.fe,
                      in_unit: i_d.in_unit};
            r_r1 <= i_d.res[R_W-1:0];
            r_k0 <= fk[21:16];
            r_f  <= fk[15:0];
            // interpolated channels
            r_t2 <= r_t1;
            r_r2 <= r_r1;
            r_c  <= n_c;
            // white blend product
            r_t3 <= r_t2;
            r_p  <= n_p;
            for (int ch = 0; ch < 3; ch++) begin
                r_hi[ch] <= r_c[ch][23:16];
            end
            // output beat
            r_t4 <= r_t3;
            r_o  <= n_o;
        end
    end

    assign o_valid      = r_t4.valid;
    assign o_red        = r_o[0];
    assign o_green      = r_o[1];
    assign o_blue       = r_o[2];
    assign o_frame_done = r_t4.fe;

endmodule

[rtl/flow_color_wheel_mapper_unit.sv]
// Channel   Direction  Handshake                 Payload
// flow in   input      i_valid / o_ready         i_flow_u, i_flow_v, i_frame_end
// pixel out output     o_valid / i_ready         o_red, o_green, o_blue, o_frame_done
// config    input      i_cfg_valid / o_cfg_ready i_cfg_inv_scale
//
// One pixel per clock while the output is not stalled; the pipeline has 5 front
// stages, N_CELLS chain cells (the CORDIC/root cells) and 4 color stages.
// Reset sets inv_scale to 1.0 and clears every stage valid bit.
// The whole pipeline holds when the output beat is pending and i_ready is low;
// a beat is taken whenever the output is empty or being drained.
module flow_color_wheel_mapper_unit
    import fcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_flow_u,
    input  logic [31:0] i_flow_v,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_frame_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_inv_scale
);

    logic en;
    logic [31:0] r_inv_scale;

    // front pipeline registers
    logic r_v0, r_v1, r_v2, r_v3;
    logic r_w0, r_w1, r_w2, r_w3;
    logic r_f0, r_f1, r_f2, r_f3;
    logic signed [31:0] r_u0, r_vv0;
    logic signed [63:0] r_pu, r_pv;
    logic signed [31:0] r_su, r_sv, r_su3, r_sv3;
    logic [63:0] r_squ, r_sqv;

    logic signed [47:0] shu, shv;
    logic signed [31:0] n_su, n_sv;
    logic [63:0] m2;
    t_cell c0;
    t_cell r_head;
    t_cell chain [N_CELLS+1];

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= 32'h0001_0000;
        end else if (i_cfg_valid) begin
            r_inv_scale <= i_cfg_inv_scale;
        end
    end

    // floor shift and saturate the scaled products
    always_comb begin
        shu = 48'(r_pu >>> 16);
        shv = 48'(r_pv >>> 16);
        if (shu > 48'sh7FFF_FFFF) begin
            n_su = 32'sh7FFF_FFFF;
        end else if (shu < -48'sh8000_0000) begin
            n_su = 32'sh8000_0000;
        end else begin
            n_su = shu[31:0];
        end
        if (shv > 48'sh7FFF_FFFF) begin
            n_sv = 32'sh7FFF_FFFF;
        end else if (shv < -48'sh8000_0000) begin
            n_sv = 32'sh8000_0000;
        end else begin
            n_sv = shv[31:0];
        end
    end

    // build the first cell input: fold the left half plane, seed the root
    always_comb begin
        m2         = r_squ + r_sqv;
        c0.valid   = r_v3;
        c0.white   = r_w3;
        c0.fe      = r_f3;
        c0.in_unit = (m2 <= UNIT_SQ);
        c0.zy      = (r_sv3 == 32'sd0);
        c0.zt      = r_su3[31] ? HALF_TURN : '0;
        c0.x       = r_su3[31] ? -XY_W'(r_su3) : XY_W'(r_su3);
        c0.y       = r_su3[31] ? -XY_W'(r_sv3) : XY_W'(r_sv3);
        c0.z       = r_su3[31] ? HALF_TURN : '0;
        c0.n       = c0.in_unit ? m2[SQ_W-1:0] : '0;
        c0.res     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_head.valid <= 1'b0;
        end else if (en) begin
            // capture the beat, flag large raw flow
            r_v0  <= i_valid;
            r_u0  <= i_flow_u;
            r_vv0 <= i_flow_v;
            r_f0  <= i_frame_end;
            r_w0  <= (64'(signed'(i_flow_u)) > WHITE_RAW)
                  && (64'(signed'(i_flow_v)) > WHITE_RAW);
            // scale by the reciprocal
            r_v1 <= r_v0;
            r_w1 <= r_w0;
            r_f1 <= r_f0;
            r_pu <= 64'(r_u0)  * signed'({32'd0, r_inv_scale});
            r_pv <= 64'(r_vv0) * signed'({32'd0, r_inv_scale});
            // saturate
            r_v2 <= r_v1;
            r_w2 <= r_w1;
            r_f2 <= r_f1;
            r_su <= n_su;
            r_sv <= n_sv;
            // squares for the magnitude
            r_v3  <= r_v2;
            r_w3  <= r_w2;
            r_f3  <= r_f2;
            r_su3 <= r_su;
            r_sv3 <= r_sv;
            r_squ <= unsigned'(64'(r_su) * 64'(r_su));
            r_sqv <= unsigned'(64'(r_sv) * 64'(r_sv));
            // hand off to the cell row
            r_head <= c0;
        end
    end

    assign chain[0] = r_head;

    // advance angle (first CORDIC_STEPS cells) and root one step per cell
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        fcw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (IDX_W'(i)),
            .i_d     (chain[i]),
            .o_q     (chain[i+1])
        );
    end

    fcw_color u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_d          (chain[N_CELLS]),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_frame_done (o_frame_done)
    );

endmodule
